// ===== hw/rtl/srr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_pkg
// Shared widths, fixed-point constants, controller states and the command and
// status bundles that join the controller and datapath of the rate reducer.
// ----------------------------------------------------------------------------
package srr_pkg;

    // Default parameter values
    localparam int DEF_SAMPLE_BITS      = 24;
    localparam int DEF_MAX_BLOCK_FRAMES = 4096;

    // Field widths
    localparam int RATE_W      = 25;   // Q1.24 rate and phase
    localparam int FRAC_W      = 24;   // fractional phase after wrap
    localparam int WET_W       = 17;   // Q1.16 wet amount
    localparam int WET_FRAC_W  = 16;
    localparam int WET_STEP_W  = 18;
    localparam int RATE_STEP_W = 26;
    localparam int FRAME_W     = 13;

    // Fixed-point constants
    localparam logic [RATE_W-1:0] ONE_RATE  = 25'd16777216;
    localparam logic [RATE_W-1:0] PHASE_MAX = 25'h1FF_FFFF;
    localparam logic [WET_W-1:0]  ONE_WET   = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRAME_PREP,
        ST_LERP_DIFF,
        ST_LERP_MUL,
        ST_LERP_SUM,
        ST_MIX_DIFF,
        ST_MIX_MUL,
        ST_FRAME_OUT,
        ST_BLOCK_PREP,
        ST_BLOCK_DIV
    } srr_state_t;

    typedef struct packed {
        logic capture;     // latch the accepted transaction
        logic frame_prep;  // wrap phase, shift held samples
        logic lerp_diff;   // magnitude of newer - older
        logic lerp_mul;    // scale by phase fraction
        logic lerp_sum;    // form interpolated sample
        logic mix_diff;    // magnitude of lerp - dry
        logic mix_mul;     // scale by wet amount
        logic emit;        // write result register, advance ramps
        logic block_init;  // load targets directly, clear history
        logic div_start;   // launch the step dividers
        logic step_load;   // store the ramp steps
    } srr_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
        logic frames_zero;
    } srr_status_t;

endpackage : srr_pkg
`default_nettype wire

// ===== hw/rtl/srr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_div
// Restoring unsigned divider, one quotient bit per cycle. Busy is high while
// quotient bits are formed after start; the quotient is valid once busy drops.
// ----------------------------------------------------------------------------
module srr_div #(
    parameter int DIVIDEND_W = 25,
    parameter int DIVISOR_W  = 13
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       busy,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    shifted;
    logic                  fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits     = shifted >= {1'b0, divisor};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIVIDEND_W);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? DIVISOR_W'(shifted - {1'b0, divisor})
                            : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && busy))
        else $error("divider restarted while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("divider did not go busy after start");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && $stable(divisor) && !$past(start)) |-> (rem_reg < divisor))
        else $error("partial remainder not below divisor");

endmodule : srr_div
`default_nettype wire

// ===== hw/rtl/srr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_ctrl
// Sequencer for the rate reducer: takes one transaction at a time and steps
// the datapath through the frame or block-start sequence.
// ----------------------------------------------------------------------------
module srr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 operation,
    output logic                      in_stall,
    input  wire srr_pkg::srr_status_t status,
    output srr_pkg::srr_cmd_t         cmd
);

    import srr_pkg::*;

    srr_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = operation ? ST_BLOCK_PREP : ST_FRAME_PREP;
                end
            end
            ST_FRAME_PREP: state_next = ST_LERP_DIFF;
            ST_LERP_DIFF:  state_next = ST_LERP_MUL;
            ST_LERP_MUL:   state_next = ST_LERP_SUM;
            ST_LERP_SUM:   state_next = ST_MIX_DIFF;
            ST_MIX_DIFF:   state_next = ST_MIX_MUL;
            ST_MIX_MUL:    state_next = ST_FRAME_OUT;
            ST_FRAME_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BLOCK_PREP:
            begin
                state_next = status.frames_zero ? ST_IDLE : ST_BLOCK_DIV;
            end
            ST_BLOCK_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_FRAME_PREP: cmd.frame_prep = 1'b1;
            ST_LERP_DIFF:  cmd.lerp_diff  = 1'b1;
            ST_LERP_MUL:   cmd.lerp_mul   = 1'b1;
            ST_LERP_SUM:   cmd.lerp_sum   = 1'b1;
            ST_MIX_DIFF:   cmd.mix_diff   = 1'b1;
            ST_MIX_MUL:    cmd.mix_mul    = 1'b1;
            ST_FRAME_OUT:  cmd.emit       = status.out_free;
            ST_BLOCK_PREP:
            begin
                cmd.block_init = status.frames_zero;
                cmd.div_start  = !status.frames_zero;
            end
            ST_BLOCK_DIV:  cmd.step_load  = !status.div_busy;
            default:       cmd            = '0;
        endcase
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !status.div_busy)
        else $error("divider running while sequencer idle");

    a_frame_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && !operation) |=>
            (state_reg == ST_FRAME_PREP))
        else $error("accepted frame did not start the frame sequence");

endmodule : srr_ctrl
`default_nettype wire

// ===== hw/rtl/srr_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srr_dp
// Datapath: phase accumulator, ramps, held sample pairs, one multiplier per
// channel shared by interpolation and mix, step dividers, result register.
// ----------------------------------------------------------------------------
module srr_dp #(
    parameter int SAMPLE_BITS      = srr_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_BLOCK_FRAMES = srr_pkg::DEF_MAX_BLOCK_FRAMES
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire srr_pkg::srr_cmd_t                   cmd,
    output srr_pkg::srr_status_t                     status,
    input  wire logic                                cfg_write_en,
    input  wire logic                                cfg_write_data,
    input  wire logic signed [SAMPLE_BITS-1:0]       in_left,
    input  wire logic signed [SAMPLE_BITS-1:0]       in_right,
    input  wire logic [srr_pkg::WET_W-1:0]           wet_target,
    input  wire logic [srr_pkg::RATE_W-1:0]          rate_target,
    input  wire logic [srr_pkg::FRAME_W-1:0]         frame_count,
    input  wire logic                                out_stall,
    output logic                                     out_valid,
    output logic signed [SAMPLE_BITS-1:0]            out_left,
    output logic signed [SAMPLE_BITS-1:0]            out_right
);

    import srr_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int PROD_W = SB + FRAC_W + 1;
    localparam logic [PROD_W-1:0] LERP_HALF = PROD_W'(1) << (FRAC_W - 1);
    localparam logic [PROD_W-1:0] MIX_HALF  = PROD_W'(1) << (WET_FRAC_W - 1);

    // Configuration and captured transaction
    logic                 mono_reg, mono_next;
    logic signed [SB-1:0] dry_reg [2];
    logic [WET_W-1:0]     wt_reg, wt_next;
    logic [RATE_W-1:0]    rt_reg, rt_next;
    logic [FRAME_W-1:0]   n_reg, n_next;

    // Architectural state
    logic [RATE_W-1:0]             phase_acc_reg, phase_acc_next;
    logic [WET_W-1:0]              wet_cur_reg, wet_cur_next;
    logic signed [WET_STEP_W-1:0]  wet_step_reg, wet_step_next;
    logic [RATE_W-1:0]             rate_cur_reg, rate_cur_next;
    logic signed [RATE_STEP_W-1:0] rate_step_reg, rate_step_next;
    logic signed [SB-1:0]          older_reg [2];
    logic signed [SB-1:0]          older_next [2];
    logic signed [SB-1:0]          newer_reg [2];
    logic signed [SB-1:0]          newer_next [2];

    // Working registers
    logic [FRAC_W-1:0]    frac_reg, frac_next;
    logic [SB:0]          mag_reg [2];
    logic [SB:0]          mag_next [2];
    logic                 neg_reg [2];
    logic                 neg_next [2];
    logic [SB:0]          prod_reg [2];
    logic [SB:0]          prod_next [2];
    logic signed [SB-1:0] lerp_reg [2];
    logic signed [SB-1:0] lerp_next [2];
    logic                 wneg_reg, wneg_next;
    logic                 rneg_reg, rneg_next;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    logic signed [SB-1:0] out_left_reg, out_left_next;
    logic signed [SB-1:0] out_right_reg, out_right_next;

    // Combinational terms
    logic                      wrap;
    logic [FRAC_W-1:0]         frac_wrapped;
    logic [RATE_W:0]           phase_sum;
    logic [RATE_W-1:0]         phase_sat;
    logic signed [SB:0]        sel_diff [2];
    logic [SB:0]               abs_diff [2];
    logic [FRAC_W-1:0]         mul_b;
    logic [PROD_W-1:0]         raw_prod [2];
    logic [PROD_W-1:0]         round_prod [2];
    logic signed [SB:0]        signed_p [2];
    logic signed [SB:0]        lerp_sum [2];
    logic signed [SB:0]        res_sum [2];
    logic signed [WET_W+1:0]   wet_sum;
    logic signed [RATE_W+1:0]  rate_sum;
    logic signed [WET_W+1:0]   wet_diff;
    logic signed [RATE_W:0]    rate_diff;
    logic [WET_W+1:0]          wet_mag;
    logic [RATE_W:0]           rate_mag;
    logic                      out_free;
    logic                      wdiv_busy, rdiv_busy;
    logic [RATE_W-1:0]         wdiv_q, rdiv_q;

    assign out_free = !out_valid_reg || !out_stall;

    // Phase wrap and advance
    always_comb
    begin
        wrap         = phase_acc_reg >= ONE_RATE;
        frac_wrapped = wrap ? FRAC_W'(phase_acc_reg - ONE_RATE)
                            : phase_acc_reg[FRAC_W-1:0];
        phase_sum    = (RATE_W+1)'(frac_wrapped) + (RATE_W+1)'(rate_cur_reg);
        phase_sat    = (phase_sum > (RATE_W+1)'(PHASE_MAX)) ? PHASE_MAX
                                                             : phase_sum[RATE_W-1:0];
    end

    // Per-channel arithmetic: one multiplier per channel, both products
    assign mul_b = cmd.lerp_mul ? frac_reg : FRAC_W'(wet_cur_reg);

    always_comb
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            if (cmd.lerp_diff)
            begin
                sel_diff[ch] = {newer_reg[ch][SB-1], newer_reg[ch]}
                             - {older_reg[ch][SB-1], older_reg[ch]};
            end
            else
            begin
                sel_diff[ch] = {lerp_reg[ch][SB-1], lerp_reg[ch]}
                             - {dry_reg[ch][SB-1], dry_reg[ch]};
            end
            abs_diff[ch]   = sel_diff[ch][SB] ? (SB+1)'(-sel_diff[ch])
                                              : (SB+1)'(sel_diff[ch]);
            raw_prod[ch]   = PROD_W'(mag_reg[ch]) * PROD_W'(mul_b);
            round_prod[ch] = raw_prod[ch] + (cmd.lerp_mul ? LERP_HALF : MIX_HALF);
            signed_p[ch]   = neg_reg[ch] ? -$signed(prod_reg[ch]) : $signed(prod_reg[ch]);
            lerp_sum[ch]   = {older_reg[ch][SB-1], older_reg[ch]} + signed_p[ch];
            res_sum[ch]    = {dry_reg[ch][SB-1], dry_reg[ch]} + signed_p[ch];
        end
    end

    // Ramps and block step dividends
    always_comb
    begin
        wet_sum   = $signed({2'b00, wet_cur_reg})
                  + $signed({wet_step_reg[WET_STEP_W-1], wet_step_reg});
        rate_sum  = $signed({2'b00, rate_cur_reg})
                  + $signed({rate_step_reg[RATE_STEP_W-1], rate_step_reg});
        wet_diff  = $signed({2'b00, wt_reg}) - $signed({2'b00, wet_cur_reg});
        rate_diff = $signed({1'b0, rt_reg}) - $signed({1'b0, rate_cur_reg});
        wet_mag   = wet_diff[WET_W+1] ? (WET_W+2)'(-wet_diff) : (WET_W+2)'(wet_diff);
        rate_mag  = rate_diff[RATE_W] ? (RATE_W+1)'(-rate_diff) : (RATE_W+1)'(rate_diff);
    end

    // Next-state logic
    always_comb
    begin
        mono_next      = cfg_write_en ? cfg_write_data : mono_reg;
        wt_next        = wt_reg;
        rt_next        = rt_reg;
        n_next         = n_reg;
        phase_acc_next = phase_acc_reg;
        wet_cur_next   = wet_cur_reg;
        wet_step_next  = wet_step_reg;
        rate_cur_next  = rate_cur_reg;
        rate_step_next = rate_step_reg;
        frac_next      = frac_reg;
        wneg_next      = wneg_reg;
        rneg_next      = rneg_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        for (int ch = 0; ch < 2; ch++)
        begin
            older_next[ch] = older_reg[ch];
            newer_next[ch] = newer_reg[ch];
            mag_next[ch]   = mag_reg[ch];
            neg_next[ch]   = neg_reg[ch];
            prod_next[ch]  = prod_reg[ch];
            lerp_next[ch]  = lerp_reg[ch];
        end

        // Clamp block targets on capture
        if (cmd.capture)
        begin
            wt_next = (wet_target > ONE_WET) ? ONE_WET : wet_target;
            rt_next = (rate_target > ONE_RATE) ? ONE_RATE : rate_target;
            n_next  = (int'(frame_count) > MAX_BLOCK_FRAMES)
                    ? FRAME_W'(MAX_BLOCK_FRAMES) : frame_count;
        end

        if (cmd.frame_prep)
        begin
            frac_next      = frac_wrapped;
            phase_acc_next = phase_sat;
            for (int ch = 0; ch < 2; ch++)
            begin
                // right channel history holds in mono
                if (wrap && (ch == 0 || !mono_reg))
                begin
                    older_next[ch] = newer_reg[ch];
                    newer_next[ch] = dry_reg[ch];
                end
            end
        end

        if (cmd.lerp_diff || cmd.mix_diff)
        begin
            for (int ch = 0; ch < 2; ch++)
            begin
                mag_next[ch] = abs_diff[ch];
                neg_next[ch] = sel_diff[ch][SB];
            end
        end

        if (cmd.lerp_mul)
        begin
            for (int ch = 0; ch < 2; ch++)
            begin
                prod_next[ch] = round_prod[ch][SB+FRAC_W:FRAC_W];
            end
        end

        if (cmd.mix_mul)
        begin
            for (int ch = 0; ch < 2; ch++)
            begin
                prod_next[ch] = round_prod[ch][SB+WET_FRAC_W:WET_FRAC_W];
            end
        end

        if (cmd.lerp_sum)
        begin
            for (int ch = 0; ch < 2; ch++)
            begin
                lerp_next[ch] = lerp_sum[ch][SB-1:0];
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_left_next  = res_sum[0][SB-1:0];
            out_right_next = mono_reg ? res_sum[0][SB-1:0] : res_sum[1][SB-1:0];
            if (wet_sum < 0)
            begin
                wet_cur_next = '0;
            end
            else if (wet_sum > $signed({2'b00, ONE_WET}))
            begin
                wet_cur_next = ONE_WET;
            end
            else
            begin
                wet_cur_next = wet_sum[WET_W-1:0];
            end
            if (rate_sum < 0)
            begin
                rate_cur_next = '0;
            end
            else if (rate_sum > $signed({2'b00, ONE_RATE}))
            begin
                rate_cur_next = ONE_RATE;
            end
            else
            begin
                rate_cur_next = rate_sum[RATE_W-1:0];
            end
        end

        if (cmd.block_init)
        begin
            wet_cur_next   = wt_reg;
            rate_cur_next  = rt_reg;
            wet_step_next  = '0;
            rate_step_next = '0;
            phase_acc_next = ONE_RATE;
            for (int ch = 0; ch < 2; ch++)
            begin
                older_next[ch] = '0;
                newer_next[ch] = '0;
            end
        end

        if (cmd.div_start)
        begin
            wneg_next = wet_diff[WET_W+1];
            rneg_next = rate_diff[RATE_W];
        end

        if (cmd.step_load)
        begin
            wet_step_next  = wneg_reg ? -$signed(WET_STEP_W'(wdiv_q))
                                      : $signed(WET_STEP_W'(wdiv_q));
            rate_step_next = rneg_reg ? -$signed(RATE_STEP_W'(rdiv_q))
                                      : $signed(RATE_STEP_W'(rdiv_q));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_acc_reg <= '0;
            wet_cur_reg   <= '0;
            wet_step_reg  <= '0;
            rate_cur_reg  <= '0;
            rate_step_reg <= '0;
            for (int ch = 0; ch < 2; ch++)
            begin
                older_reg[ch] <= '0;
                newer_reg[ch] <= '0;
            end
        end
        else
        begin
            mono_reg      <= mono_next;
            out_valid_reg <= out_valid_next;
            phase_acc_reg <= phase_acc_next;
            wet_cur_reg   <= wet_cur_next;
            wet_step_reg  <= wet_step_next;
            rate_cur_reg  <= rate_cur_next;
            rate_step_reg <= rate_step_next;
            for (int ch = 0; ch < 2; ch++)
            begin
                older_reg[ch] <= older_next[ch];
                newer_reg[ch] <= newer_next[ch];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dry_reg[0] <= in_left;
            dry_reg[1] <= in_right;
        end
        wt_reg        <= wt_next;
        rt_reg        <= rt_next;
        n_reg         <= n_next;
        frac_reg      <= frac_next;
        wneg_reg      <= wneg_next;
        rneg_reg      <= rneg_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        for (int ch = 0; ch < 2; ch++)
        begin
            mag_reg[ch]  <= mag_next[ch];
            neg_reg[ch]  <= neg_next[ch];
            prod_reg[ch] <= prod_next[ch];
            lerp_reg[ch] <= lerp_next[ch];
        end
    end

    srr_div #(
        .DIVIDEND_W (RATE_W),
        .DIVISOR_W  (FRAME_W)
    ) u_wet_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (RATE_W'(wet_mag)),
        .divisor  (n_reg),
        .busy     (wdiv_busy),
        .quotient (wdiv_q)
    );

    srr_div #(
        .DIVIDEND_W (RATE_W),
        .DIVISOR_W  (FRAME_W)
    ) u_rate_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rate_mag[RATE_W-1:0]),
        .divisor  (n_reg),
        .busy     (rdiv_busy),
        .quotient (rdiv_q)
    );

    assign status.div_busy    = wdiv_busy || rdiv_busy;
    assign status.out_free    = out_free;
    assign status.frames_zero = n_reg == '0;

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

    a_wet_range: assert property (@(posedge clk) disable iff (!rst_n)
        wet_cur_reg <= ONE_WET)
        else $error("wet ramp outside its range");

    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        rate_cur_reg <= ONE_RATE)
        else $error("rate ramp outside its range");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten before it was taken");

endmodule : srr_dp
`default_nettype wire

// ===== hw/rtl/sample_rate_reducer_lerp_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sample_rate_reducer_lerp_unit
// Lo-fi resampler with linear interpolation and dry/wet mix, stereo or mono.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per item:
//   operation 0 is an audio frame, operation 1 starts a block with new wet
//   and rate targets over frame_count frames (0 re-initializes the state).
//   Output channel (out_valid / out_stall) returns one result per audio
//   frame; block starts return nothing. cfg_write_en / cfg_write_data set the
//   mono flag; write it only while the block is idle.
// Sequencing:
//   An audio frame is sequenced through phase wrap, difference, multiply and
//   sum steps for interpolation and then for mix; its result is registered
//   in the output step, which waits until the result register is free, and
//   the next transaction is taken only once the block is idle again. A block
//   start with nonzero count runs the two bit-serial step dividers in
//   parallel; a count of 0 skips them. One transaction is in work at a time.
// Reset:
//   rst_n clears phase, ramps, steps, held samples, mono flag and the output
//   register; the first result appears only after a new frame.
// Backpressure:
//   The result register holds while out_stall is high; the block keeps taking
//   a transaction and works on it until it needs the result register, then
//   holds in its last step.
// ----------------------------------------------------------------------------
module sample_rate_reducer_lerp_unit #(
    parameter int SAMPLE_BITS      = srr_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_BLOCK_FRAMES = srr_pkg::DEF_MAX_BLOCK_FRAMES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_write_en,
    input  wire logic                          cfg_write_data,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          operation,
    input  wire logic signed [SAMPLE_BITS-1:0] in_left,
    input  wire logic signed [SAMPLE_BITS-1:0] in_right,
    input  wire logic [srr_pkg::WET_W-1:0]     wet_target,
    input  wire logic [srr_pkg::RATE_W-1:0]    rate_target,
    input  wire logic [srr_pkg::FRAME_W-1:0]   frame_count,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      out_left,
    output logic signed [SAMPLE_BITS-1:0]      out_right
);

    import srr_pkg::*;

    srr_cmd_t    cmd;
    srr_status_t status;

    // Sequencer: accept, then step the datapath
    srr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: state, arithmetic, dividers and result register
    srr_dp #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_left        (in_left),
        .in_right       (in_right),
        .wet_target     (wet_target),
        .rate_target    (rate_target),
        .frame_count    (frame_count),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .out_left       (out_left),
        .out_right      (out_right)
    );

endmodule : sample_rate_reducer_lerp_unit
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the interpolating sample rate reducer. A table of
// directed transactions is walked first, then randomized blocks of frames run
// under both mono settings with random gaps and stalls on both channels. Each
// accepted transaction goes through a bit-true model of the phase, ramps and
// held samples; results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

    import srr_pkg::*;

    localparam int  SW           = DEF_SAMPLE_BITS;
    localparam int  MAX_FRAMES   = DEF_MAX_BLOCK_FRAMES;
    localparam int  DIR_ROWS     = 25;
    localparam int  DRAIN_CYCLES = 40;      // lets a block start with divide finish
    localparam int  HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // Transaction kinds on the input channel
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_BLOCK = 1'b1;

    localparam logic signed [SW-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SW-1:0] S_MIN = 24'sh800000;

    localparam longint RATE_ONE_L  = ONE_RATE;
    localparam longint WET_ONE_L   = ONE_WET;
    localparam longint PHASE_TOP_L = PHASE_MAX;

    // One input transaction; known/exp_* carry a hand-typed expectation
    typedef struct packed {
        logic                 op;
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic [WET_W-1:0]     wet;
        logic [RATE_W-1:0]    rate;
        logic [FRAME_W-1:0]   frames;
        logic                 known;
        logic signed [SW-1:0] exp_l;
        logic signed [SW-1:0] exp_r;
    } stim_t;

    typedef struct packed {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
    } frame_t;

    // ------------------------------------------------------------------------
    // Clock, DUT signals
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;
    logic in_valid;
    logic in_stall;
    logic out_valid;
    logic out_stall;
    logic signed [SW-1:0] out_left;
    logic signed [SW-1:0] out_right;

    stim_t cur_item;   // transaction currently offered on the input channel

    logic                 operation;
    logic signed [SW-1:0] in_left;
    logic signed [SW-1:0] in_right;
    logic [WET_W-1:0]     wet_target;
    logic [RATE_W-1:0]    rate_target;
    logic [FRAME_W-1:0]   frame_count;

    assign operation   = cur_item.op;
    assign in_left     = cur_item.left;
    assign in_right    = cur_item.right;
    assign wet_target  = cur_item.wet;
    assign rate_target = cur_item.rate;
    assign frame_count = cur_item.frames;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sample_rate_reducer_lerp_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .in_left        (in_left),
        .in_right       (in_right),
        .wet_target     (wet_target),
        .rate_target    (rate_target),
        .frame_count    (frame_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_left       (out_left),
        .out_right      (out_right)
    );

    // ------------------------------------------------------------------------
    // Resampler model state (mirrors the block after reset)
    // ------------------------------------------------------------------------
    logic                         m_mono      = 1'b0;
    logic [RATE_W-1:0]            m_phase     = '0;
    logic [WET_W-1:0]             m_wet       = '0;
    logic signed [WET_STEP_W-1:0] m_wet_step  = '0;
    logic [RATE_W-1:0]            m_rate      = '0;
    logic signed [RATE_STEP_W-1:0] m_rate_step = '0;
    logic signed [SW-1:0]         m_older [2] = '{default: '0};
    logic signed [SW-1:0]         m_newer [2] = '{default: '0};

    frame_t expected_frames [$];   // results still owed by the block
    int     fail_count = 0;
    logic   hold_req   = 1'b0;     // ask the receiver for a long hold-off
    logic   idle_on    = 1'b1;     // random gaps and stalls enabled
    int unsigned cycle_count = 0;

    // (d * f) / 2^sh, rounded to nearest with ties away from zero
    function automatic longint round_scale(input longint d, input longint f, input int sh);
        longint mag;
        longint p;
        mag = (d < 0) ? -d : d;
        p   = (mag * f + (longint'(1) << (sh - 1))) >>> sh;
        return (d < 0) ? -p : p;
    endfunction

    function automatic longint clamp_ramp(input longint v, input longint hi);
        if (v < 0)
        begin
            return 0;
        end
        return (v > hi) ? hi : v;
    endfunction

    // Advance the model by one accepted transaction; emits is set when a
    // result is owed
    task automatic advance_resampler(input stim_t s, output logic emits, output frame_t res);
        longint wt, rt, n, lerp, p;
        longint dry [2];
        longint outv [2];
        int     nch;
        int     ch;
        emits = 1'b0;
        res   = '0;
        if (s.op == OP_BLOCK)
        begin
            wt = (longint'(s.wet) > WET_ONE_L) ? WET_ONE_L : longint'(s.wet);
            rt = (longint'(s.rate) > RATE_ONE_L) ? RATE_ONE_L : longint'(s.rate);
            n  = (longint'(s.frames) > longint'(MAX_FRAMES)) ? longint'(MAX_FRAMES)
                                                              : longint'(s.frames);
            if (n != 0)
            begin
                // truncating division toward zero, so ramps may fall short
                m_wet_step  = WET_STEP_W'((wt - longint'(m_wet)) / n);
                m_rate_step = RATE_STEP_W'((rt - longint'(m_rate)) / n);
            end
            else
            begin
                // initialize: jump to targets, force a wrap on the next frame
                m_wet       = WET_W'(wt);
                m_wet_step  = '0;
                m_rate      = RATE_W'(rt);
                m_rate_step = '0;
                m_phase     = ONE_RATE;
                m_older     = '{default: '0};
                m_newer     = '{default: '0};
            end
            return;
        end

        nch    = m_mono ? 1 : 2;
        dry[0] = longint'($signed(s.left));
        dry[1] = longint'($signed(s.right));

        if (m_phase >= ONE_RATE)
        begin
            m_phase = m_phase - ONE_RATE;
            for (ch = 0; ch < nch; ch++)
            begin
                m_older[ch] = m_newer[ch];
                m_newer[ch] = SW'(dry[ch]);
            end
        end
        for (ch = 0; ch < nch; ch++)
        begin
            lerp = longint'(m_older[ch]) +
                   round_scale(longint'(m_newer[ch]) - longint'(m_older[ch]),
                               longint'(m_phase), 24);
            outv[ch] = dry[ch] + round_scale(lerp - dry[ch], longint'(m_wet), 16);
        end
        if (nch == 1)
        begin
            outv[1] = outv[0];
        end
        res.left  = SW'(outv[0]);
        res.right = SW'(outv[1]);
        emits     = 1'b1;

        p       = longint'(m_phase) + longint'(m_rate);
        m_phase = RATE_W'((p > PHASE_TOP_L) ? PHASE_TOP_L : p);
        m_wet   = WET_W'(clamp_ramp(longint'(m_wet) + longint'(m_wet_step), WET_ONE_L));
        m_rate  = RATE_W'(clamp_ramp(longint'(m_rate) + longint'(m_rate_step),
                                     RATE_ONE_L));
    endtask

    function automatic void note_failure(input string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: check results, track the mono register, predict on accept
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        frame_t want;
        frame_t pred;
        logic   emits;
        if (rst_n)
        begin
            // Check the result first: it belongs to an older transaction
            if (out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    note_failure($sformatf("unexpected result, got left %0d right %0d",
                                           out_left, out_right));
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (out_left !== want.left)
                    begin
                        note_failure($sformatf("out_left expected %0d, got %0d",
                                               $signed(want.left), out_left));
                    end
                    if (out_right !== want.right)
                    begin
                        note_failure($sformatf("out_right expected %0d, got %0d",
                                               $signed(want.right), out_right));
                    end
                end
            end
            if (cfg_write_en)
            begin
                m_mono = cfg_write_data;
            end
            if (in_valid && !in_stall)
            begin
                advance_resampler(cur_item, emits, pred);
                if (emits)
                begin
                    // hand-typed rows override the model's prediction
                    if (cur_item.known)
                    begin
                        pred.left  = cur_item.exp_l;
                        pred.right = cur_item.exp_r;
                    end
                    expected_frames.push_back(pred);
                end
            end
        end
    end

    // Watchdog: fail the run when it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_frames.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int r;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // hold the output so the block fills and stalls its input
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!idle_on)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    out_stall <= 1'b0;
                end
                else if (r < 96)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(0, 3)) @(negedge clk);
                end
                else
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(15, 80)) @(negedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!idle_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // Offer one transaction and hold it until the block accepts it
    task automatic send_item(input stim_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cur_item <= s;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // Drop valid, wait for every owed result, then let a silent block start
    // finish before touching the register
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mono(input logic value);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    function automatic logic signed [SW-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            return S_MAX;
        end
        if (r == 1)
        begin
            return S_MIN;
        end
        return SW'($urandom);
    endfunction

    function automatic stim_t rand_frame();
        stim_t s;
        s        = '0;
        s.op     = OP_FRAME;
        s.left   = rand_sample();
        s.right  = rand_sample();
        // block-only fields are don't-care here; toggle them anyway
        s.wet    = WET_W'($urandom);
        s.rate   = RATE_W'($urandom);
        s.frames = FRAME_W'($urandom);
        return s;
    endfunction

    function automatic stim_t rand_block();
        stim_t s;
        int    r;
        s       = '0;
        s.op    = OP_BLOCK;
        s.left  = SW'($urandom);
        s.right = SW'($urandom);
        r = $urandom_range(0, 9);
        case (r)
            0:       s.wet = WET_W'($urandom);      // may exceed 1.0, saturates
            1:       s.wet = '0;
            2:       s.wet = ONE_WET;
            default: s.wet = WET_W'($urandom_range(0, 65536));
        endcase
        r = $urandom_range(0, 9);
        case (r)
            0:       s.rate = RATE_W'($urandom);    // may exceed 1.0, saturates
            1:       s.rate = '0;
            2:       s.rate = ONE_RATE;
            3, 4:    s.rate = RATE_W'($urandom_range(0, 1 << 22));
            default: s.rate = RATE_W'($urandom_range(0, 1 << 24));
        endcase
        r = $urandom_range(0, 19);
        case (r)
            0, 1, 2: s.frames = '0;                 // re-initialize
            3:       s.frames = FRAME_W'($urandom); // may exceed the maximum
            4:       s.frames = FRAME_W'(MAX_FRAMES);
            default: s.frames = FRAME_W'($urandom_range(1, 32));
        endcase
        return s;
    endfunction

    function automatic stim_t row(input logic op, input logic signed [SW-1:0] l,
                                  input logic signed [SW-1:0] r, input int wet,
                                  input int rate, input int frames, input logic known,
                                  input logic signed [SW-1:0] el,
                                  input logic signed [SW-1:0] er);
        stim_t s;
        s.op     = op;
        s.left   = l;
        s.right  = r;
        s.wet    = WET_W'(wet);
        s.rate   = RATE_W'(rate);
        s.frames = FRAME_W'(frames);
        s.known  = known;
        s.exp_l  = el;
        s.exp_r  = er;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table. Typed expectations: after reset and after a zero-wet
    // init the output is the dry input; after a fully wet init with rate 0
    // the interpolator sits on the cleared older sample, so the output is 0.
    // ------------------------------------------------------------------------
    stim_t dir_tab [DIR_ROWS];

    initial
    begin
        dir_tab[0]  = row(OP_FRAME, S_MAX, S_MIN, 0, 0, 0, 1'b1, S_MAX, S_MIN);
        dir_tab[1]  = row(OP_FRAME, S_MIN, S_MAX, 0, 0, 0, 1'b1, S_MIN, S_MAX);
        dir_tab[2]  = row(OP_FRAME, 24'sh2AAAAA, -24'sd5, 0, 0, 0, 1'b1,
                          24'sh2AAAAA, -24'sd5);
        // init with everything at zero
        dir_tab[3]  = row(OP_BLOCK, 0, 0, 0, 0, 0, 1'b0, 0, 0);
        dir_tab[4]  = row(OP_FRAME, 24'sd12345, -24'sd6789, 0, 0, 0, 1'b1,
                          24'sd12345, -24'sd6789);
        // init fully wet, frozen phase
        dir_tab[5]  = row(OP_BLOCK, 0, 0, 65536, 0, 0, 1'b0, 0, 0);
        dir_tab[6]  = row(OP_FRAME, S_MAX, S_MIN, 0, 0, 0, 1'b1, 0, 0);
        dir_tab[7]  = row(OP_FRAME, S_MIN, S_MAX, 0, 0, 0, 1'b1, 0, 0);
        // init with both targets above range: they saturate
        dir_tab[8]  = row(OP_BLOCK, S_MAX, S_MAX, 131071, 33554431, 0, 1'b0, 0, 0);
        dir_tab[9]  = row(OP_FRAME, S_MAX, S_MIN, 0, 0, 0, 1'b0, 0, 0);
        dir_tab[10] = row(OP_FRAME, S_MIN, S_MAX, 0, 0, 0, 1'b0, 0, 0);
        dir_tab[11] = row(OP_FRAME, -24'sd1, 24'sd1, 0, 0, 0, 1'b0, 0, 0);
        // frame count above the maximum acts as the maximum
        dir_tab[12] = row(OP_BLOCK, S_MIN, S_MIN, 0, 16777216, 8191, 1'b0, 0, 0);
        dir_tab[13] = row(OP_FRAME, S_MAX, S_MIN, 0, 0, 0, 1'b0, 0, 0);
        dir_tab[14] = row(OP_FRAME, -24'sd1, 24'sd1, 0, 0, 0, 1'b0, 0, 0);
        // one-frame ramp to full wet and quarter rate, then past the block end
        dir_tab[15] = row(OP_BLOCK, 0, 0, 65536, 4194304, 1, 1'b0, 0, 0);
        dir_tab[16] = row(OP_FRAME, 24'sh400000, -24'sh400000, 0, 0, 0, 1'b0, 0, 0);
        dir_tab[17] = row(OP_FRAME, S_MAX, S_MIN, 0, 0, 0, 1'b0, 0, 0);
        dir_tab[18] = row(OP_FRAME, S_MIN, S_MAX, 0, 0, 0, 1'b0, 0, 0);
        // steps that truncate toward zero
        dir_tab[19] = row(OP_BLOCK, 0, 0, 32768, 1, 3, 1'b0, 0, 0);
        dir_tab[20] = row(OP_FRAME, 24'sd1000, -24'sd1000, 0, 0, 0, 1'b0, 0, 0);
        dir_tab[21] = row(OP_FRAME, S_MAX, S_MIN, 0, 0, 0, 1'b0, 0, 0);
        dir_tab[22] = row(OP_FRAME, 24'sd3, -24'sd3, 0, 0, 0, 1'b0, 0, 0);
        dir_tab[23] = row(OP_FRAME, S_MIN, S_MAX, 0, 0, 0, 1'b0, 0, 0);
        dir_tab[24] = row(OP_FRAME, 24'sh123456, -24'sh654321, 0, 0, 0, 1'b0, 0, 0);
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int   i;
        int   ph;
        int   sent;
        int   nfr;
        logic hold_done;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        in_valid       = 1'b0;
        cur_item       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, stereo (mono flag is clear after reset)
        for (i = 0; i < DIR_ROWS; i++)
        begin
            send_item(dir_tab[i]);
        end

        // Random part: six phases alternating mono and stereo. Each phase
        // starts from an idle block, so every phase start is also a pause
        // on the sender side until all results are in.
        for (ph = 0; ph < 6; ph++)
        begin
            settle_block();
            write_mono((ph % 2) == 0);
            sent      = 0;
            hold_done = 1'b0;
            while (sent < 250)
            begin
                // some sequences run with no idling at all
                idle_on = ($urandom_range(0, 3) != 0);
                send_item(rand_block());
                sent++;
                nfr = $urandom_range(1, 40);
                repeat (nfr)
                begin
                    send_item(rand_frame());
                    sent++;
                    if ((ph == 1 || ph == 4) && !hold_done && sent >= 60)
                    begin
                        // keep offering frames while the receiver holds off
                        hold_req  = 1'b1;
                        hold_done = 1'b1;
                    end
                end
            end
        end

        idle_on = 1'b1;
        settle_block();

        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
